>>> rtl/core/rwsch_pkg.sv
package rwsch_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned TS_W    = 32;
    localparam int unsigned ENTRY_W = ID_W + TS_W;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_LAND    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TAKEOFF = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_ADMITTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LANDED   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_TOOK_OFF = 3'd3;
    localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // one finished item as seen by the statistics block
    typedef struct packed {
        logic            idle;
        logic            land_refused;
        logic            takeoff_refused;
        logic            landed;
        logic            took_off;
        logic [TS_W-1:0] wait_val;
    } rwsch_event_t;

endpackage

>>> rtl/core/rwsch_queue.sv
module rwsch_queue
    import rwsch_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  logic [ENTRY_W-1:0]             push_data,
    input  logic                           pop,
    output logic [ENTRY_W-1:0]             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]     fill
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      tail_reg;
    logic [FW-1:0]      fill_reg;

    // storage: one write port at the tail, one registered read at the head
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
        if (pop) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                tail_reg <= (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            if (pop) begin
                head_reg <= (head_reg == LAST) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (32'(fill_reg) < 32'(DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (fill_reg != '0))
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == FW'($past(fill_reg) + 1'b1)))
        else $error("fill did not follow push");

endmodule

>>> rtl/core/rwsch_stats.sv
module rwsch_stats
    import rwsch_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ev_valid,
    input  rwsch_event_t      ev,
    output logic [SUM_W-1:0]  land_wait_total,
    output logic [SUM_W-1:0]  takeoff_wait_total,
    output logic [CNT_W-1:0]  idle_ticks,
    output logic [CNT_W-1:0]  land_refused_total,
    output logic [CNT_W-1:0]  takeoff_refused_total,
    output logic [CNT_W-1:0]  landings_total,
    output logic [CNT_W-1:0]  takeoffs_total
);

    logic [SUM_W-1:0] land_sum_reg;
    logic [SUM_W-1:0] take_sum_reg;
    logic [CNT_W-1:0] idle_reg;
    logic [CNT_W-1:0] land_ref_reg;
    logic [CNT_W-1:0] take_ref_reg;
    logic [CNT_W-1:0] landings_reg;
    logic [CNT_W-1:0] takeoffs_reg;
    logic [SUM_W:0]   land_sum_ext;
    logic [SUM_W:0]   take_sum_ext;
    logic [SUM_W-1:0] land_sum_next;
    logic [SUM_W-1:0] take_sum_next;

    // saturating wait sums
    always_comb begin
        land_sum_ext  = {1'b0, land_sum_reg} + (SUM_W + 1)'(ev.wait_val);
        take_sum_ext  = {1'b0, take_sum_reg} + (SUM_W + 1)'(ev.wait_val);
        land_sum_next = land_sum_ext[SUM_W] ? SUM_MAX : land_sum_ext[SUM_W-1:0];
        take_sum_next = take_sum_ext[SUM_W] ? SUM_MAX : take_sum_ext[SUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            land_sum_reg <= '0;
            take_sum_reg <= '0;
            idle_reg     <= '0;
            land_ref_reg <= '0;
            take_ref_reg <= '0;
            landings_reg <= '0;
            takeoffs_reg <= '0;
        end else if (ev_valid) begin
            if (ev.landed) begin
                land_sum_reg <= land_sum_next;
                if (landings_reg != CNT_MAX) landings_reg <= landings_reg + 1'b1;
            end
            if (ev.took_off) begin
                take_sum_reg <= take_sum_next;
                if (takeoffs_reg != CNT_MAX) takeoffs_reg <= takeoffs_reg + 1'b1;
            end
            if (ev.idle && idle_reg != CNT_MAX) begin
                idle_reg <= idle_reg + 1'b1;
            end
            if (ev.land_refused && land_ref_reg != CNT_MAX) begin
                land_ref_reg <= land_ref_reg + 1'b1;
            end
            if (ev.takeoff_refused && take_ref_reg != CNT_MAX) begin
                take_ref_reg <= take_ref_reg + 1'b1;
            end
        end
    end

    assign land_wait_total       = land_sum_reg;
    assign takeoff_wait_total    = take_sum_reg;
    assign idle_ticks            = idle_reg;
    assign land_refused_total    = land_ref_reg;
    assign takeoff_refused_total = take_ref_reg;
    assign landings_total        = landings_reg;
    assign takeoffs_total        = takeoffs_reg;

    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid |-> $onehot({ev.idle, ev.land_refused, ev.takeoff_refused,
                              ev.landed, ev.took_off}) || !(ev.idle || ev.land_refused
                              || ev.takeoff_refused || ev.landed || ev.took_off))
        else $error("more than one event per item");

    a_land_sum_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (land_sum_reg >= $past(land_sum_reg)))
        else $error("landing wait sum went down");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !ev_valid |=> $stable(idle_reg) && $stable(landings_reg) && $stable(takeoffs_reg))
        else $error("counter moved without an event");

endmodule

>>> rtl/core/two_queue_priority_runway_scheduler.sv
// strict-priority runway scheduler with two bounded queues
//
// input channel (s_*): one beat is a landing request, a takeoff request or a
// runway tick; action code 3 is taken and dropped with no result beat.
// result channel (m_*): one beat per request or tick, carrying the status,
// the served plane and its wait, both queue fills and all statistics.
// config: APB-style port, admit_limit at byte address 0 (per-queue cap).
//
// each beat passes ST_IDLE and ST_FINISH: the accept cycle writes the tail or
// issues the head read on the queue memory, the next cycle sees the registered
// read data and loads the result register. the registered memory read is why a
// beat finishes in ST_FINISH, and no new beat is taken before it has finished.
// a new beat is taken in the same cycle that the previous result leaves.
//
// reset (aresetn low, synchronous) empties both queues, clears all counters
// and sets admit_limit to 1024; queue memory contents are not cleared.
// when the receiver stalls, the result register holds and s_ready stays low
// until the pending result beat is taken.
module two_queue_priority_runway_scheduler
    import rwsch_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACT_W-1:0]     s_action,
    input  logic [ID_W-1:0]      s_plane_id,
    input  logic [TS_W-1:0]      s_time_stamp,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STAT_W-1:0]    m_status,
    output logic [ID_W-1:0]      m_served_id,
    output logic [TS_W-1:0]      m_wait_time,
    output logic [COUNT_W-1:0]   m_land_queue_count,
    output logic [COUNT_W-1:0]   m_takeoff_queue_count,
    output logic [SUM_W-1:0]     m_land_wait_total,
    output logic [SUM_W-1:0]     m_takeoff_wait_total,
    output logic [CNT_W-1:0]     m_idle_ticks,
    output logic [CNT_W-1:0]     m_land_refused_total,
    output logic [CNT_W-1:0]     m_takeoff_refused_total,
    output logic [CNT_W-1:0]     m_landings_total,
    output logic [CNT_W-1:0]     m_takeoffs_total,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic ADDR_ADMIT_LIMIT = 1'b0;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [COUNT_W-1:0]  limit_reg;

    // item captured at accept, finished in ST_FINISH
    logic [ACT_W-1:0]    act_reg;
    logic [STAT_W-1:0]   pend_status_reg;
    logic [TS_W-1:0]     ts_reg;

    // result register
    logic                m_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [ID_W-1:0]     served_reg;
    logic [TS_W-1:0]     wait_reg;

    logic                accept;
    logic                is_land;
    logic                is_take;
    logic                is_tick;
    logic                land_admit;
    logic                take_admit;
    logic                land_push;
    logic                take_push;
    logic                land_pop;
    logic                take_pop;
    logic [ENTRY_W-1:0]  entry;
    logic [ENTRY_W-1:0]  land_rd;
    logic [ENTRY_W-1:0]  take_rd;
    logic [ENTRY_W-1:0]  head_entry;
    logic [FW-1:0]       land_fill;
    logic [FW-1:0]       take_fill;
    logic [TS_W-1:0]     wait_val;
    logic [STAT_W-1:0]   pend_status_next;
    logic                ev_valid;
    rwsch_event_t        ev;

    // config port: single register, zero-wait writes
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_ADMIT_LIMIT) ? 32'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ADDR_ADMIT_LIMIT) begin
            limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // one item in flight; the result slot must be free or draining
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign is_land = (s_action == ACT_LAND);
    assign is_take = (s_action == ACT_TAKEOFF);
    assign is_tick = (s_action == ACT_TICK);

    // admission: below the programmed limit and below the physical depth
    assign land_admit = (32'(land_fill) < 32'(limit_reg))
                     && (32'(land_fill) < 32'(QUEUE_DEPTH));
    assign take_admit = (32'(take_fill) < 32'(limit_reg))
                     && (32'(take_fill) < 32'(QUEUE_DEPTH));

    assign entry     = {s_time_stamp, s_plane_id};
    assign land_push = accept && is_land && land_admit;
    assign take_push = accept && is_take && take_admit;

    // landing queue always wins the runway
    assign land_pop = accept && is_tick && (land_fill != '0);
    assign take_pop = accept && is_tick && (land_fill == '0) && (take_fill != '0);

    always_comb begin
        pend_status_next = STAT_IDLE;
        case (s_action)
            ACT_LAND:    pend_status_next = land_admit ? STAT_ADMITTED : STAT_REFUSED;
            ACT_TAKEOFF: pend_status_next = take_admit ? STAT_ADMITTED : STAT_REFUSED;
            ACT_TICK: begin
                if (land_fill != '0) begin
                    pend_status_next = STAT_LANDED;
                end else if (take_fill != '0) begin
                    pend_status_next = STAT_TOOK_OFF;
                end else begin
                    pend_status_next = STAT_IDLE;
                end
            end
            default:     pend_status_next = STAT_IDLE;
        endcase
    end

    rwsch_queue #(
        .DEPTH     (QUEUE_DEPTH)
    ) u_land_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (land_push),
        .push_data (entry),
        .pop       (land_pop),
        .rd_data   (land_rd),
        .fill      (land_fill)
    );

    rwsch_queue #(
        .DEPTH     (QUEUE_DEPTH)
    ) u_takeoff_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take_push),
        .push_data (entry),
        .pop       (take_pop),
        .rd_data   (take_rd),
        .fill      (take_fill)
    );

    // finish stage: head data is valid here, wait wraps modulo 2^32
    assign head_entry = (pend_status_reg == STAT_LANDED) ? land_rd : take_rd;
    assign wait_val   = ts_reg - head_entry[ENTRY_W-1:ID_W];

    assign ev_valid           = (state_reg == ST_FINISH);
    assign ev.idle            = (pend_status_reg == STAT_IDLE);
    assign ev.land_refused    = (pend_status_reg == STAT_REFUSED) && (act_reg == ACT_LAND);
    assign ev.takeoff_refused = (pend_status_reg == STAT_REFUSED)
                             && (act_reg == ACT_TAKEOFF);
    assign ev.landed          = (pend_status_reg == STAT_LANDED);
    assign ev.took_off        = (pend_status_reg == STAT_TOOK_OFF);
    assign ev.wait_val        = wait_val;

    rwsch_stats u_stats (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .ev_valid              (ev_valid),
        .ev                    (ev),
        .land_wait_total       (m_land_wait_total),
        .takeoff_wait_total    (m_takeoff_wait_total),
        .idle_ticks            (m_idle_ticks),
        .land_refused_total    (m_land_refused_total),
        .takeoff_refused_total (m_takeoff_refused_total),
        .landings_total        (m_landings_total),
        .takeoffs_total        (m_takeoffs_total)
    );

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_action != ACT_NONE) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    state_reg   <= ST_IDLE;
                    m_valid_reg <= 1'b1;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg         <= s_action;
            pend_status_reg <= pend_status_next;
            ts_reg          <= s_time_stamp;
        end
        if (state_reg == ST_FINISH) begin
            status_reg <= pend_status_reg;
            if (ev.landed || ev.took_off) begin
                served_reg <= head_entry[ID_W-1:0];
                wait_reg   <= wait_val;
            end else begin
                served_reg <= '0;
                wait_reg   <= '0;
            end
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_status              = status_reg;
    assign m_served_id           = served_reg;
    assign m_wait_time           = wait_reg;
    assign m_land_queue_count    = COUNT_W'(land_fill);
    assign m_takeoff_queue_count = COUNT_W'(take_fill);

    // result slot is always empty when an item finishes
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> !m_valid_reg)
        else $error("result register overwritten");

    // a result beat is raised only by a finishing item in ST_FINISH
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat without an item");

    // never pop both queues for one tick
    a_single_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(land_pop && take_pop))
        else $error("both queues served on one tick");

endmodule
